// File: hdl/sfd_pkg.sv
// sfd_pkg: shared types, codes and helpers for the serial float frame deframer
// no dependencies; used by every module of the block

package sfd_pkg;

    // frame delimiters
    localparam logic [7:0] HDR_SYNC  = 8'h55;
    localparam logic [7:0] HDR_ZERO  = 8'h00;
    localparam logic [7:0] TRL_ZERO  = 8'h00;
    localparam logic [7:0] TRL_FRESH = 8'hAA;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGHEST_ID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_IN_USE = 2'd1;

    // word slot field of a queued command, wide enough for sixteen words
    localparam int unsigned SLOT_W = 4;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_ZERO  = 6'b000010,
        PH_ID    = 6'b000100,
        PH_COUNT = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_END   = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_CHECK = 3'b010,
        BK_EMIT  = 3'b100
    } back_state_t;

    // command from the parser to the emitter
    // is_end = 0: store data into lane of pending word slot
    // is_end = 1: close frame, data holds the frame id, fresh commits pending words
    typedef struct packed {
        logic              is_end;
        logic              fresh;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        lane;
        logic [7:0]        data;
    } cmd_t;

    function automatic logic is_normal(input logic [31:0] w);
        return (w[30:23] != 8'h00) && (w[30:23] != 8'hFF);
    endfunction

endpackage

// File: hdl/sfd_front.sv
// sfd_front: byte parser, hunts for frame headers and turns payload and trailer
// bytes into commands for the emitter; depends on sfd_pkg

module sfd_front #(
    parameter int unsigned MAX_WORDS = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  logic [7:0]    highest_id,
    input  logic [4:0]    words_in_use,
    output logic          q_push,
    output sfd_pkg::cmd_t q_cmd,
    input  logic          q_full
);

    sfd_pkg::phase_t phase_reg, phase_next;
    logic [6:0] count_reg, count_next;
    logic [7:0] id_reg, id_next;
    logic       take;
    logic       in_payload;

    assign s_ready    = !q_full;
    assign take       = s_valid && s_ready;
    assign in_payload = count_reg < {words_in_use, 2'b00};

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        id_next    = id_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.slot = count_reg[sfd_pkg::SLOT_W+1:2];
        q_cmd.lane = count_reg[1:0];
        q_cmd.data = s_rx_byte;
        if (take) begin
            case (phase_reg)
                sfd_pkg::PH_HUNT: begin
                    if (s_rx_byte == sfd_pkg::HDR_SYNC) phase_next = sfd_pkg::PH_ZERO;
                end
                sfd_pkg::PH_ZERO: begin
                    phase_next = (s_rx_byte == sfd_pkg::HDR_ZERO) ? sfd_pkg::PH_ID
                                                                  : sfd_pkg::PH_HUNT;
                end
                sfd_pkg::PH_ID: begin
                    if (s_rx_byte <= highest_id) begin
                        id_next    = s_rx_byte;
                        phase_next = sfd_pkg::PH_COUNT;
                    end else begin
                        phase_next = sfd_pkg::PH_HUNT;
                    end
                end
                sfd_pkg::PH_COUNT: begin
                    if (s_rx_byte == {3'b000, words_in_use}) begin
                        phase_next = sfd_pkg::PH_DATA;
                        count_next = '0;
                    end else begin
                        phase_next = sfd_pkg::PH_HUNT;
                    end
                end
                sfd_pkg::PH_DATA: begin
                    if (in_payload) begin
                        // bytes past the last stored word are counted only
                        q_push     = count_reg[6:2] < 5'(MAX_WORDS);
                        count_next = count_reg + 7'd1;
                    end else begin
                        phase_next = (s_rx_byte == sfd_pkg::TRL_ZERO) ? sfd_pkg::PH_END
                                                                      : sfd_pkg::PH_HUNT;
                    end
                end
                sfd_pkg::PH_END: begin
                    q_push       = 1'b1;
                    q_cmd.is_end = 1'b1;
                    q_cmd.fresh  = s_rx_byte == sfd_pkg::TRL_FRESH;
                    q_cmd.data   = id_reg;
                    phase_next   = sfd_pkg::PH_HUNT;
                end
                default: phase_next = sfd_pkg::PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfd_pkg::PH_HUNT;
            count_reg <= '0;
            id_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            id_reg    <= id_next;
        end
    end

endmodule

// File: hdl/sfd_queue.sv
// sfd_queue: short command queue between parser and emitter
// depends on sfd_pkg for the command type

module sfd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output sfd_pkg::cmd_t pop_cmd,
    output logic          empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::cmd_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = slots_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) slots_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            if (pop)  rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

// File: hdl/sfd_back.sv
// sfd_back: executes parser commands, holds pending and stored words and
// streams the stored frame out through a registered result stage; depends on sfd_pkg

module sfd_back #(
    parameter int unsigned MAX_WORDS = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  sfd_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_id,
    output logic [3:0]    m_word_index,
    output logic [31:0]   m_word_value,
    output logic          m_fresh,
    output logic          m_normal_ok,
    output logic          m_last
);

    localparam int unsigned IDX_W = $clog2(MAX_WORDS);

    sfd_pkg::back_state_t state_reg, state_next;

    logic [31:0]      pending_reg [MAX_WORDS];
    logic [31:0]      stored_reg  [MAX_WORDS];
    logic [IDX_W-1:0] k_reg;
    logic [7:0]       id_reg;
    logic             fresh_reg;
    logic             ok_reg;
    logic             m_valid_reg;
    logic             slot_free;
    logic             emit;
    logic             k_last;
    logic [IDX_W-1:0] wr_slot;

    assign slot_free = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == sfd_pkg::BK_IDLE) && !q_empty;
    assign emit      = (state_reg == sfd_pkg::BK_EMIT) && slot_free;
    assign k_last    = k_reg == IDX_W'(MAX_WORDS - 1);
    assign wr_slot   = q_cmd.slot[IDX_W-1:0];
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfd_pkg::BK_IDLE:  if (q_pop && q_cmd.is_end) state_next = sfd_pkg::BK_CHECK;
            sfd_pkg::BK_CHECK: state_next = sfd_pkg::BK_EMIT;
            sfd_pkg::BK_EMIT:  if (emit && k_last) state_next = sfd_pkg::BK_IDLE;
            default:           state_next = sfd_pkg::BK_IDLE;
        endcase
    end

    // pending words: no reset, every used byte is written before a commit
    always_ff @(posedge aclk) begin
        if (q_pop && !q_cmd.is_end) begin
            pending_reg[wr_slot][{q_cmd.lane, 3'b000} +: 8] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WORDS; i++) stored_reg[i] <= '0;
        end else if (q_pop && q_cmd.is_end && q_cmd.fresh) begin
            for (int i = 0; i < MAX_WORDS; i++) stored_reg[i] <= pending_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfd_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sfd_pkg::BK_CHECK) k_reg <= '0;
            else if (emit) k_reg <= k_reg + IDX_W'(1);
            if (emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.is_end) begin
            id_reg    <= q_cmd.data;
            fresh_reg <= q_cmd.fresh;
        end
        if (state_reg == sfd_pkg::BK_CHECK) begin
            ok_reg <= sfd_pkg::is_normal(stored_reg[0]) && sfd_pkg::is_normal(stored_reg[1])
                   && sfd_pkg::is_normal(stored_reg[2]);
        end
        if (emit) begin
            m_frame_id   <= ok_reg ? id_reg : 8'h00;
            m_word_index <= 4'(k_reg);
            m_word_value <= stored_reg[k_reg];
            m_fresh      <= fresh_reg;
            m_normal_ok  <= ok_reg;
            m_last       <= k_last;
        end
    end

    a_check_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sfd_pkg::BK_CHECK |=> state_reg == sfd_pkg::BK_EMIT && k_reg == '0)
        else $error("emit did not start after normality check");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == sfd_pkg::BK_IDLE)
        else $error("command taken while a frame is streaming");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && k_last |=> state_reg == sfd_pkg::BK_IDLE && m_valid_reg && m_last)
        else $error("frame did not close after its final word");

endmodule

// File: hdl/serial_float_frame_deframer.sv
// serial_float_frame_deframer: top level, configuration registers and the
// parser / queue / emitter chain; depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
// throughput: one byte per cycle while the command queue has room; each payload byte
//   costs the emitter one queue pop, a closing byte a pop, the BK_CHECK state and MAX_WORDS
//   result transfers, one per cycle when m_ready stays high; the closing command passes
//   the queue, BK_IDLE, BK_CHECK and BK_EMIT before the first word is registered out
// reset: synchronous active-low aresetn; parser hunts for 0x55, queue empty,
//   stored words and id zero, registers back to highest_id 3 and words_in_use 11

module serial_float_frame_deframer #(
    parameter int unsigned MAX_WORDS   = 11,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_frame_id,
    output logic [3:0]                      m_word_index,
    output logic [31:0]                     m_word_value,
    output logic                            m_fresh,
    output logic                            m_normal_ok,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    logic [7:0]    highest_id_reg;
    logic [4:0]    words_in_use_reg;
    logic          q_push, q_pop, q_full, q_empty;
    sfd_pkg::cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_id_reg   <= 8'd3;
            words_in_use_reg <= 5'd11;
        end else if (cfg_valid) begin
            case (cfg_index)
                sfd_pkg::REG_HIGHEST_ID:   highest_id_reg   <= cfg_data;
                sfd_pkg::REG_WORDS_IN_USE: words_in_use_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    sfd_front #(.MAX_WORDS(MAX_WORDS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .highest_id   (highest_id_reg),
        .words_in_use (words_in_use_reg),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .q_full       (q_full)
    );

    sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    sfd_back #(.MAX_WORDS(MAX_WORDS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_id   (m_frame_id),
        .m_word_index (m_word_index),
        .m_word_value (m_word_value),
        .m_fresh      (m_fresh),
        .m_normal_ok  (m_normal_ok),
        .m_last       (m_last)
    );

endmodule
